/* src/b2ss_pkg.sv */
// Package with shared widths, defaults and the seven-segment lookup.
package b2ss_pkg;

  localparam int unsigned VALUE_W    = 20;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned SEL_W      = 8;
  localparam int unsigned NUM_DIGITS = 6;

  // Common-cathode patterns, bit order gfedcba, decimal point off.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h27;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

/* src/b2ss_cell.sv */
// One shift-and-add-3 step of the binary to BCD conversion chain.
module b2ss_cell import b2ss_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [4*NumDigits-1:0] bcd_i,
  input  logic [VALUE_W-1:0]     bin_i,
  output logic                   valid_o,
  output logic [4*NumDigits-1:0] bcd_o,
  output logic [VALUE_W-1:0]     bin_o
);

  logic                   valid_q;
  logic [4*NumDigits-1:0] bcd_q, bcd_d, adj;
  logic [VALUE_W-1:0]     bin_q, bin_d;

  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_i[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_i[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_i[4*d +: 4];
      end
    end
    // Carries out of the top digit are dropped, which keeps the value modulo 10^NumDigits.
    bcd_d = {adj[4*NumDigits-2:0], bin_i[VALUE_W-1]};
    bin_d = {bin_i[VALUE_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

/* src/b2ss_serializer.sv */
// Output stage scanning the digits out as one display word per cycle unless stalled.
module b2ss_serializer import b2ss_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pipe_valid_i,
  input  logic [4*NumDigits-1:0] pipe_bcd_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WORD_W-1:0]      display_word_o,
  output logic [POS_W-1:0]       digit_position_o,
  output logic                   last_digit_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(NumDigits - 1);

  logic                   valid_q, valid_d;
  logic [POS_W-1:0]       pos_q, pos_d, idx;
  logic [4*NumDigits-1:0] digits_q;
  logic [3:0]             cur_digit;
  logic [SEL_W-1:0]       sel;
  logic                   is_last, out_acc, load;

  assign is_last = (pos_q == LastPos);
  assign out_acc = valid_q && !out_stall_i;
  assign take_o  = !valid_q || (out_acc && is_last);
  assign load    = take_o && pipe_valid_i;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    if (load) begin
      valid_d = 1'b1;
      pos_d   = '0;
    end else if (out_acc) begin
      if (is_last) begin
        valid_d = 1'b0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= pipe_bcd_i;
    end
  end

  // Position zero is the most significant digit, held in the top nibble.
  assign idx       = LastPos - pos_q;
  assign cur_digit = 4'(digits_q >> {idx, 2'b00});
  assign sel       = SEL_W'(~(SEL_W'(1) << pos_q));

  assign out_valid_o      = valid_q;
  assign display_word_o   = {sel, seg_pattern(cur_digit)};
  assign digit_position_o = pos_q;
  assign last_digit_o     = is_last;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> pos_q <= LastPos)
    else $error("digit position beyond the last digit");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !is_last) |=> (valid_q && pos_q == $past(pos_q) + 1'b1))
    else $error("digit position did not advance after a taken word");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && is_last && pipe_valid_i) |=> (valid_q && pos_q == '0))
    else $error("next request not loaded after the last word");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && is_last && !pipe_valid_i) |=> !valid_q)
    else $error("output still valid after the last word with nothing queued");
`endif

endmodule

/* src/binary_to_seven_segment_scan.sv */
// Top level of the binary to seven-segment scan encoder.
//
// Input channel: value_i with in_valid_i / in_stall_o; a request is taken at a
// rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: display_word_o, digit_position_o and last_digit_o with
// out_valid_o / out_stall_i. Each request yields NumDigits words, most
// significant digit first, and last_digit_o marks the final one.
// The value is converted by a chain of VALUE_W shift-and-add-3 cells, one bit
// per cell, and the first word appears once the result reaches the scan stage.
// The scan stage then puts out one word per cycle while out_stall_i is low, so
// each request holds the scan stage for NumDigits words. New requests keep
// entering the chain while earlier words are still being scanned out.
// While the receiver stalls, the current word holds, and once the chain's end
// holds a finished value that cannot be handed over, the whole chain and the
// input stall with it.
// Reset clears all valid flags; no words are pending after reset.
module binary_to_seven_segment_scan import b2ss_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WORD_W-1:0]   display_word_o,
  output logic [POS_W-1:0]    digit_position_o,
  output logic                last_digit_o
);

  logic                   valid_c [VALUE_W+1];
  logic [4*NumDigits-1:0] bcd_c   [VALUE_W+1];
  logic [VALUE_W-1:0]     bin_c   [VALUE_W+1];
  logic                   take, adv;

  // The chain moves as one unless a finished value waits at its end.
  assign adv        = !valid_c[VALUE_W] || take;
  assign in_stall_o = !adv;

  assign valid_c[0] = in_valid_i;
  assign bcd_c[0]   = '0;
  assign bin_c[0]   = value_i;

  for (genvar i = 0; i < VALUE_W; i++) begin : g_cell
    b2ss_cell #(
      .NumDigits (NumDigits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valid_c[i]),
      .bcd_i   (bcd_c[i]),
      .bin_i   (bin_c[i]),
      .valid_o (valid_c[i+1]),
      .bcd_o   (bcd_c[i+1]),
      .bin_o   (bin_c[i+1])
    );
  end

  b2ss_serializer #(
    .NumDigits (NumDigits)
  ) u_serializer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pipe_valid_i     (valid_c[VALUE_W]),
    .pipe_bcd_i       (bcd_c[VALUE_W]),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .display_word_o   (display_word_o),
    .digit_position_o (digit_position_o),
    .last_digit_o     (last_digit_o)
  );

endmodule
